// ===== design/timed_step_sequence_player_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the step sequence player
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TIMED_STEP_SEQUENCE_PLAYER_ASSERT_SVH
`define TIMED_STEP_SEQUENCE_PLAYER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSSP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("%m: check failed");

// The consequent must hold in the cycle after the antecedent.
`define TSSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

// ===== design/tssp_pkg.sv =====
// ----------------------------------------------------------------------------
// Step sequence player package
// Word types, opcodes, field codes, constants and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package tssp_pkg;

	localparam int DEF_STEPS_PER_SEQ = 16;
	localparam int NUM_SEQ           = 4;
	localparam int NUM_MOTORS        = 6;
	// Words kept per step: six angles, lifter, delay and flags.
	localparam int NUM_FIELDS        = 9;
	localparam int LEN_W             = 5;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_MODE  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;

	localparam logic [3:0] FI_LIFTER = 4'd6;
	localparam logic [3:0] FI_DELAY  = 4'd7;
	localparam logic [3:0] FI_FLAGS  = 4'd8;

	localparam logic [1:0] CFG_IDLE_LEN = 2'd0;
	localparam logic [1:0] CFG_LOW_LEN  = 2'd1;
	localparam logic [1:0] CFG_PICK_LEN = 2'd2;
	localparam logic [1:0] CFG_HIGH_LEN = 2'd3;

	localparam logic [1:0] MODE_IDLE = 2'd0;

	// Tag of the fetch slot that carries the lifter word; angles use 0 to 5.
	localparam logic [2:0] TAG_LIFTER = 3'd6;

	// round(pi / 180 * 2^32)
	localparam logic [26:0] DEG2RAD_Q32 = 27'd74961321;

	typedef struct packed {
		logic [1:0]         opcode;
		logic signed [31:0] mode_req;
		logic [1:0]         seq_id;
		logic [3:0]         step_num;
		logic [3:0]         field_index;
		logic signed [31:0] field_value;
		logic [31:0]        time_ms;
	} item_t;

	typedef struct packed {
		logic               motor_valid;
		logic               lifter_valid;
		logic signed [31:0] motor1_rad;
		logic signed [31:0] motor2_rad;
		logic signed [31:0] motor3_rad;
		logic signed [31:0] motor4_rad;
		logic signed [31:0] motor5_rad;
		logic signed [31:0] motor6_rad;
		logic signed [15:0] lifter_target;
	} result_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_FLAGS,
		ST_DELAY,
		ST_FETCH,
		ST_DRAIN
	} state_t;

endpackage

`default_nettype wire

// ===== design/tssp_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tssp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== design/timed_step_sequence_player.sv =====
// ----------------------------------------------------------------------------
// Timed step sequence player
// Plays one of four stored step sequences and emits motor and lifter targets.
// ----------------------------------------------------------------------------
// Usage:
// Words enter on the item channel (item_valid / item_ready / item). A table
// write stores one field of one step, a mode command restarts the sequence of
// the requested mode, and a tick either emits the flagged targets of the
// current step or advances to the next step once its delay has run out.
// Sequence lengths are set on the cfg channel, which is always ready; the user
// must write it only while the block is idle; the block does not enforce this.
// Only a tick that emits targets produces a result word on the result channel
// (result_valid / result_ready / result), held in an output register.
// A tick that only checks the delay passes through the look and delay states;
// a tick that emits reads the flags word, then six angles and the lifter word
// one per cycle from the single step memory port, then passes them through the
// shared multiplier pipeline.
// A stalled receiver does not block further words; only a tick that has a new
// result waits in its last state until the output register is free.
// After reset the step memory is swept to zero, one word per cycle, over all
// 36 * STEPS_PER_SEQ words (576 at the default); no item is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

`include "timed_step_sequence_player_assert.svh"

module timed_step_sequence_player #(
	parameter int STEPS_PER_SEQ = tssp_pkg::DEF_STEPS_PER_SEQ
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         item_valid,
	output logic                              item_ready,
	input  wire tssp_pkg::item_t              item,
	output logic                              result_valid,
	input  wire logic                         result_ready,
	output tssp_pkg::result_t                 result,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [1:0]                   cfg_index,
	input  wire logic [tssp_pkg::LEN_W-1:0]   cfg_data
);

	// Every step owns NUM_FIELDS consecutive words of one memory.
	localparam int SLOTS  = tssp_pkg::NUM_SEQ * STEPS_PER_SEQ;
	localparam int DEPTH  = SLOTS * tssp_pkg::NUM_FIELDS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int POS_W  = $clog2(STEPS_PER_SEQ + 1);
	localparam int CMP_W  = POS_W + tssp_pkg::LEN_W;

	tssp_pkg::state_t state_q, state_d;

	logic [tssp_pkg::LEN_W-1:0] idle_len_q, low_len_q, pick_len_q, high_len_q;

	logic [1:0]       mode_q;
	logic             running_q;
	logic [POS_W-1:0] pos_q;
	logic             sent_q;
	logic [31:0]      start_q;
	logic [31:0]      now_q;
	logic [1:0]       flags_q;
	logic [ADDR_W-1:0] clr_q;
	logic [2:0]       k_q;

	// Shared conversion pipeline: memory read, magnitude, product, rounding.
	logic        vld_s1_q, vld_s2_q, vld_s3_q;
	logic [2:0]  tag_s1_q, tag_s2_q, tag_s3_q;
	logic        neg_s2_q, neg_s3_q;
	logic [31:0] mag_s2_q;
	logic [58:0] prod_s3_q;

	logic [31:0] motor_w_q [tssp_pkg::NUM_MOTORS];
	logic [15:0] lifter_w_q;

	logic              result_valid_q;
	tssp_pkg::result_t result_q, result_d;
	logic              load_res;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [31:0]       ram_wdata, ram_rdata;

	logic              accept;
	logic              cmd_ok, cmd_same, wr_ok, pos_end, advance;
	logic [CMP_W-1:0]  cur_len, cmd_len;
	logic [ADDR_W-1:0] cur_slot, cur_base, wr_slot, wr_addr;
	logic [31:0]       elapsed;
	logic [31:0]       abs_val;
	logic [58:0]       rnd_sum;
	logic [26:0]       rnd;
	logic [31:0]       motor_val;
	logic [32:0]       lif_sum;
	logic [16:0]       lif_r, lif_neg;
	logic [15:0]       lif_val;

	function automatic logic [CMP_W-1:0] clamp_len(input logic [tssp_pkg::LEN_W-1:0] n);
		if (CMP_W'(n) > CMP_W'(STEPS_PER_SEQ)) begin
			return CMP_W'(STEPS_PER_SEQ);
		end
		return CMP_W'(n);
	endfunction

	function automatic logic [tssp_pkg::LEN_W-1:0] len_of(input logic [1:0] m,
			input logic [tssp_pkg::LEN_W-1:0] l0, input logic [tssp_pkg::LEN_W-1:0] l1,
			input logic [tssp_pkg::LEN_W-1:0] l2, input logic [tssp_pkg::LEN_W-1:0] l3);
		logic [tssp_pkg::LEN_W-1:0] n;
		unique case (m)
			tssp_pkg::CFG_IDLE_LEN: n = l0;
			tssp_pkg::CFG_LOW_LEN:  n = l1;
			tssp_pkg::CFG_PICK_LEN: n = l2;
			default:                n = l3;
		endcase
		return n;
	endfunction

	tssp_ram #(
		.WIDTH (32),
		.DEPTH (DEPTH)
	) u_step_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign accept    = item_valid && item_ready;
	assign cfg_ready = 1'b1;

	// Lengths are clamped to the table size and read fresh at every use.
	assign cur_len = clamp_len(len_of(mode_q, idle_len_q, low_len_q, pick_len_q, high_len_q));
	assign cmd_len = clamp_len(len_of(item.mode_req[1:0], idle_len_q, low_len_q,
		pick_len_q, high_len_q));
	assign pos_end = CMP_W'(pos_q) >= cur_len;

	assign cmd_ok   = item.mode_req[31:2] == 30'd0;
	assign cmd_same = (item.mode_req[1:0] == mode_q) && running_q;
	assign wr_ok    = (32'(item.step_num) < STEPS_PER_SEQ) &&
		(item.field_index <= tssp_pkg::FI_FLAGS);

	// Word address of a step is slot * 9, built as slot * 8 + slot.
	assign cur_slot = ADDR_W'(mode_q) * ADDR_W'(STEPS_PER_SEQ) + ADDR_W'(pos_q);
	assign cur_base = (cur_slot << 3) + cur_slot;
	assign wr_slot  = ADDR_W'(item.seq_id) * ADDR_W'(STEPS_PER_SEQ) + ADDR_W'(item.step_num);
	assign wr_addr  = (wr_slot << 3) + wr_slot + ADDR_W'(item.field_index);

	// A negative delay always expires; otherwise compare the wrapped elapsed time.
	assign elapsed = now_q - start_q;
	assign advance = ram_rdata[31] || (elapsed >= ram_rdata);

	assign abs_val = ram_rdata[31] ? (~ram_rdata + 32'd1) : ram_rdata;

	// Angle rounding: half away from zero on the magnitude, sign put back after.
	assign rnd_sum   = prod_s3_q + 59'h0_8000_0000;
	assign rnd       = rnd_sum[58:32];
	assign motor_val = neg_s3_q ? (32'd0 - 32'(rnd)) : 32'(rnd);

	// Lifter rounding to whole mm with saturation to the signed 16-bit range.
	assign lif_sum = {1'b0, mag_s2_q} + 33'h0_0000_8000;
	assign lif_r   = lif_sum[32:16];
	assign lif_neg = 17'd0 - lif_r;
	always_comb begin
		if (neg_s2_q) begin
			lif_val = (lif_r > 17'd32768) ? 16'h8000 : lif_neg[15:0];
		end else begin
			lif_val = (lif_r > 17'd32767) ? 16'h7FFF : lif_r[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tssp_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = wr_addr;
		ram_wdata  = (item.field_index == tssp_pkg::FI_FLAGS) ?
			{30'd0, item.field_value[1:0]} : item.field_value;
		ram_raddr  = cur_base + ADDR_W'(k_q);
		load_res   = 1'b0;
		unique case (state_q)
			tssp_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				if (clr_q == ADDR_W'(DEPTH - 1)) begin
					state_d = tssp_pkg::ST_IDLE;
				end
			end
			tssp_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					unique case (item.opcode)
						tssp_pkg::OP_WRITE: ram_we = wr_ok;
						tssp_pkg::OP_TICK: begin
							if (running_q) begin
								state_d = tssp_pkg::ST_LOOK;
							end
						end
						default: ;
					endcase
				end
			end
			tssp_pkg::ST_LOOK: begin
				if (pos_end) begin
					state_d = tssp_pkg::ST_IDLE;
				end else if (!sent_q) begin
					ram_raddr = cur_base + ADDR_W'(tssp_pkg::FI_FLAGS);
					state_d   = tssp_pkg::ST_FLAGS;
				end else begin
					ram_raddr = cur_base + ADDR_W'(tssp_pkg::FI_DELAY);
					state_d   = tssp_pkg::ST_DELAY;
				end
			end
			tssp_pkg::ST_FLAGS: begin
				if (ram_rdata[1:0] == 2'b00) begin
					state_d = tssp_pkg::ST_IDLE;
				end else begin
					state_d = tssp_pkg::ST_FETCH;
				end
			end
			tssp_pkg::ST_DELAY: state_d = tssp_pkg::ST_IDLE;
			tssp_pkg::ST_FETCH: begin
				if (k_q == tssp_pkg::TAG_LIFTER) begin
					state_d = tssp_pkg::ST_DRAIN;
				end
			end
			tssp_pkg::ST_DRAIN: begin
				if (!vld_s1_q && !vld_s2_q && !vld_s3_q &&
						(!result_valid_q || result_ready)) begin
					load_res = 1'b1;
					state_d  = tssp_pkg::ST_IDLE;
				end
			end
			default: state_d = tssp_pkg::ST_IDLE;
		endcase
	end

	// Control state of the player.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_len_q     <= '0;
			low_len_q      <= '0;
			pick_len_q     <= '0;
			high_len_q     <= '0;
			mode_q         <= tssp_pkg::MODE_IDLE;
			running_q      <= 1'b0;
			pos_q          <= '0;
			sent_q         <= 1'b0;
			start_q        <= '0;
			clr_q          <= '0;
			k_q            <= '0;
			vld_s1_q       <= 1'b0;
			vld_s2_q       <= 1'b0;
			vld_s3_q       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					tssp_pkg::CFG_IDLE_LEN: idle_len_q <= cfg_data;
					tssp_pkg::CFG_LOW_LEN:  low_len_q  <= cfg_data;
					tssp_pkg::CFG_PICK_LEN: pick_len_q <= cfg_data;
					default:                high_len_q <= cfg_data;
				endcase
			end

			unique case (state_q)
				tssp_pkg::ST_CLEAR: clr_q <= clr_q + 1'b1;
				tssp_pkg::ST_IDLE: begin
					if (accept && (item.opcode == tssp_pkg::OP_MODE) && cmd_ok && !cmd_same) begin
						mode_q    <= item.mode_req[1:0];
						pos_q     <= '0;
						sent_q    <= 1'b0;
						start_q   <= '0;
						running_q <= cmd_len != '0;
					end
				end
				tssp_pkg::ST_LOOK: begin
					if (pos_end) begin
						mode_q    <= tssp_pkg::MODE_IDLE;
						running_q <= 1'b0;
					end
				end
				tssp_pkg::ST_FLAGS: begin
					sent_q  <= 1'b1;
					start_q <= now_q;
					k_q     <= '0;
				end
				tssp_pkg::ST_DELAY: begin
					if (advance) begin
						pos_q  <= pos_q + 1'b1;
						sent_q <= 1'b0;
					end
				end
				tssp_pkg::ST_FETCH: k_q <= k_q + 1'b1;
				default: ;
			endcase

			vld_s1_q <= state_q == tssp_pkg::ST_FETCH;
			vld_s2_q <= vld_s1_q;
			vld_s3_q <= vld_s2_q && (tag_s2_q != tssp_pkg::TAG_LIFTER);

			if (load_res) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: operands flowing through the shared multiplier and
	// the converted targets of the step being played.
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q <= item.time_ms;
		end
		if (state_q == tssp_pkg::ST_FLAGS) begin
			flags_q <= ram_rdata[1:0];
		end
		tag_s1_q  <= k_q;
		mag_s2_q  <= abs_val;
		neg_s2_q  <= ram_rdata[31];
		tag_s2_q  <= tag_s1_q;
		prod_s3_q <= 59'(mag_s2_q) * 59'(tssp_pkg::DEG2RAD_Q32);
		neg_s3_q  <= neg_s2_q;
		tag_s3_q  <= tag_s2_q;
		if (vld_s2_q && (tag_s2_q == tssp_pkg::TAG_LIFTER)) begin
			lifter_w_q <= lif_val;
		end
		if (vld_s3_q && (tag_s3_q < tssp_pkg::TAG_LIFTER)) begin
			motor_w_q[tag_s3_q] <= motor_val;
		end
		if (load_res) begin
			result_q <= result_d;
		end
	end

	// Unflagged targets are sent as zero.
	always_comb begin
		result_d.motor_valid   = flags_q[0];
		result_d.lifter_valid  = flags_q[1];
		result_d.motor1_rad    = flags_q[0] ? motor_w_q[0] : '0;
		result_d.motor2_rad    = flags_q[0] ? motor_w_q[1] : '0;
		result_d.motor3_rad    = flags_q[0] ? motor_w_q[2] : '0;
		result_d.motor4_rad    = flags_q[0] ? motor_w_q[3] : '0;
		result_d.motor5_rad    = flags_q[0] ? motor_w_q[4] : '0;
		result_d.motor6_rad    = flags_q[0] ? motor_w_q[5] : '0;
		result_d.lifter_target = flags_q[1] ? lifter_w_q : '0;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Fetching targets only happens for a running step whose actions are marked sent.
	`TSSP_ASSERT_IMP(a_fetch_ctx, clk, arst_n,
		(state_q == tssp_pkg::ST_FETCH) || (state_q == tssp_pkg::ST_DRAIN), running_q && sent_q)
	// A running sequence never points past the end of its table.
	`TSSP_ASSERT_IMP(a_pos_bound, clk, arst_n,
		running_q, CMP_W'(pos_q) <= CMP_W'(STEPS_PER_SEQ))
	// Only angle words reach the rounding stage.
	`TSSP_ASSERT_IMP(a_s3_angle, clk, arst_n, vld_s3_q, tag_s3_q < tssp_pkg::TAG_LIFTER)
	// A loaded result always carries at least one target.
	`TSSP_ASSERT_NEXT(a_res_flag, clk, arst_n,
		load_res, result_valid && (result.motor_valid || result.lifter_valid))

endmodule

`default_nettype wire
